// ===== rtl/gcms_pkg.sv =====
// ----------------------------------------------------------------------------
// gcms_pkg
// Shared types and constants for the convex minorant slope block.
// ----------------------------------------------------------------------------
package gcms_pkg;

  // Diagram capacity and derived index widths
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Field widths
  localparam int W_W       = 40;              // cumulative weight, Q24.16
  localparam int S_W       = 48;              // cumulative sum, signed Q32.16
  localparam int SL_W      = 48;              // internal slope, signed Q32.16
  localparam int OUT_W     = 17;              // clipped slope, Q1.16
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = S_W + FRAC_BITS; // divider numerator width
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // Slope limits
  localparam logic signed [SL_W-1:0] SLOPE_MAX = {1'b0, {(SL_W-1){1'b1}}};
  localparam logic signed [SL_W-1:0] SLOPE_MIN = {1'b1, {(SL_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]       SLOPE_ONE = OUT_W'(1) << FRAC_BITS;

  // One point of the cumulative sum diagram
  typedef struct packed {
    logic [W_W-1:0]        cum_weight;
    logic signed [S_W-1:0] cum_sum;
    logic                  last_point;
  } point_t;

  // One emitted slope
  typedef struct packed {
    logic [OUT_W-1:0] slope;
    logic             zero_weight;
    logic             last_slope;
  } slope_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,      // taking points
    ST_I_RD,      // read point i
    ST_I_LAT,     // latch point i
    ST_CH_RD,     // read chord start point a
    ST_CH_SUB,    // form sum and weight differences
    ST_CH_SETUP,  // zero weight check, start divider
    ST_CH_DIV,    // wait on divider, saturate
    ST_PUT,       // store first slope of point i
    ST_WH_TEST,   // test for a point to the left
    ST_WH_CMP,    // compare left slope against current
    ST_FILL,      // copy pooled slope over j..i
    ST_EM_RD,     // read slope for emission
    ST_EM_LAT,    // clip into output register
    ST_EM_WAIT    // wait for receiver
  } state_t;

endpackage

// ===== rtl/gcms_div.sv =====
// ----------------------------------------------------------------------------
// gcms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcms_div import gcms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [W_W-1:0]   den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [W_W-1:0]       rem;
  logic [W_W-1:0]       rem_next;
  logic [NUM_W-1:0]     acc;
  logic [W_W:0]         trial;
  logic                 fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, acc[NUM_W-1]};
    fits  = (trial >= {1'b0, den});
    if (fits) begin
      rem_next = W_W'(trial - {1'b0, den});
    end else begin
      rem_next = trial[W_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in behind the numerator
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
    end else if (run) begin
      acc <= {acc[NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quo = acc;

endmodule

// ===== rtl/greatest_convex_minorant_slopes.sv =====
// ----------------------------------------------------------------------------
// greatest_convex_minorant_slopes
// Left slopes of the greatest convex minorant of a cumulative sum diagram.
// ----------------------------------------------------------------------------
// Usage:
//   Points of the diagram arrive on the pt channel, one transaction each, in
//   order; the origin (0,0) is implied. Up to MAX_POINTS points are stored,
//   further points are dropped. The point with last_point set starts the
//   pool-adjacent-violators pass; pt_stall stays high from then until the
//   final slope has been taken.
//   pt_stall stays low while loading, so points can follow back to back.
//   The pass runs one chord at a time through a single bit-serial divider
//   that forms the quotient one bit at a time over the whole numerator. The
//   first chord of a point reads the point and the chord start, forms the
//   differences, runs the divider and then stores the slope and compares it
//   with the slope to its left. A pooled chord reads the new start point,
//   divides again and copies the pooled slope over every point of the pool.
//   A chord with a non-increasing weight skips the divider. Slopes then
//   leave on the sl channel, one per point; sl_stall holds the current slope
//   in the output register until it is taken. Reset clears the point count
//   and the weight flag; stored points need no clearing.
// ----------------------------------------------------------------------------
module greatest_convex_minorant_slopes import gcms_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pt_valid,
  output logic   pt_stall,
  input  point_t pt_data,
  output logic   sl_valid,
  input  logic   sl_stall,
  output slope_t sl_data
);

  state_t state;
  state_t state_next;

  // Point and slope stores
  logic [W_W-1:0]         weight_mem [MAX_POINTS];
  logic signed [S_W-1:0]  sum_mem    [MAX_POINTS];
  logic signed [SL_W-1:0] slope_mem  [MAX_POINTS];

  logic [CNT_W-1:0] count;
  logic             err;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] m;
  logic [CNT_W-1:0] a;
  logic             pool;

  logic [W_W-1:0]         wi;
  logic signed [S_W-1:0]  si;
  logic [W_W-1:0]         rd_w;
  logic signed [S_W-1:0]  rd_s;
  logic signed [SL_W-1:0] rd_sl;
  logic signed [S_W:0]    dsum;
  logic signed [W_W:0]    dw;
  logic signed [SL_W-1:0] cur;

  logic             pt_acc;
  logic             room;
  logic [CNT_W-1:0] pt_raddr_full;
  logic [CNT_W-1:0] sl_raddr_full;
  logic [CNT_W-1:0] sl_waddr_full;
  logic             sl_we;
  logic             dw_bad;
  logic [S_W-1:0]   dsum_abs;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic             div_over;
  logic signed [SL_W-1:0] sat_slope;
  logic signed [SL_W-1:0] bad_slope;
  logic             left_higher;
  logic [OUT_W-1:0] clip;

  assign pt_stall = (state != ST_LOAD);
  assign pt_acc   = pt_valid && !pt_stall;
  assign room     = (count < CNT_W'(MAX_POINTS));

  // Store addresses
  assign pt_raddr_full = ((state == ST_I_RD) ? i : a) - CNT_W'(1);
  assign sl_raddr_full = (state == ST_WH_TEST) ? (j - CNT_W'(2)) : (m - CNT_W'(1));
  assign sl_waddr_full = ((state == ST_PUT) ? i : m) - CNT_W'(1);
  assign sl_we         = (state == ST_PUT) || (state == ST_FILL);

  // Point store: written while loading, read during the pass
  always_ff @(posedge clk) begin
    if (pt_acc && room) begin
      weight_mem[count[IDX_W-1:0]] <= pt_data.cum_weight;
      sum_mem[count[IDX_W-1:0]]    <= pt_data.cum_sum;
    end
    rd_w <= weight_mem[pt_raddr_full[IDX_W-1:0]];
    rd_s <= sum_mem[pt_raddr_full[IDX_W-1:0]];
  end

  // Slope store
  always_ff @(posedge clk) begin
    if (sl_we) begin
      slope_mem[sl_waddr_full[IDX_W-1:0]] <= cur;
    end
    rd_sl <= slope_mem[sl_raddr_full[IDX_W-1:0]];
  end

  // Chord setup: zero weight check and magnitude of the sum difference
  assign dw_bad    = dw[W_W] || (dw == '0);
  assign dsum_abs  = dsum[S_W] ? S_W'(-dsum) : S_W'(dsum);
  assign bad_slope = dsum[S_W] ? SLOPE_MIN : SLOPE_MAX;
  assign div_start = (state == ST_CH_SETUP) && !dw_bad;

  gcms_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({dsum_abs, {FRAC_BITS{1'b0}}}),
    .den   (dw[W_W-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Quotient saturation and sign
  assign div_over = |div_quo[NUM_W-1:SL_W-1];
  always_comb begin
    if (!dsum[S_W]) begin
      sat_slope = div_over ? SLOPE_MAX : div_quo[SL_W-1:0];
    end else begin
      sat_slope = div_over ? SLOPE_MIN : SL_W'(0) - div_quo[SL_W-1:0];
    end
  end

  assign left_higher = (rd_sl > cur);

  // Clip to [0,1]
  always_comb begin
    if (rd_sl[SL_W-1] || (rd_sl == '0)) begin
      clip = '0;
    end else if (rd_sl >= SL_W'(SLOPE_ONE)) begin
      clip = SLOPE_ONE;
    end else begin
      clip = rd_sl[OUT_W-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (pt_acc && pt_data.last_point) begin
          state_next = ST_I_RD;
        end
      end
      ST_I_RD:     state_next = ST_I_LAT;
      ST_I_LAT:    state_next = ST_CH_RD;
      ST_CH_RD:    state_next = ST_CH_SUB;
      ST_CH_SUB:   state_next = ST_CH_SETUP;
      ST_CH_SETUP: begin
        if (dw_bad) begin
          state_next = pool ? ST_FILL : ST_PUT;
        end else begin
          state_next = ST_CH_DIV;
        end
      end
      ST_CH_DIV: begin
        if (div_done) begin
          state_next = pool ? ST_FILL : ST_PUT;
        end
      end
      ST_PUT:      state_next = ST_WH_TEST;
      ST_WH_TEST: begin
        if (j > CNT_W'(1)) begin
          state_next = ST_WH_CMP;
        end else if (i == count) begin
          state_next = ST_EM_RD;
        end else begin
          state_next = ST_I_RD;
        end
      end
      ST_WH_CMP: begin
        if (left_higher) begin
          state_next = ST_CH_RD;
        end else if (i == count) begin
          state_next = ST_EM_RD;
        end else begin
          state_next = ST_I_RD;
        end
      end
      ST_FILL: begin
        if (m == i) begin
          state_next = ST_WH_TEST;
        end
      end
      ST_EM_RD:    state_next = ST_EM_LAT;
      ST_EM_LAT:   state_next = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (!sl_stall) begin
          state_next = (m == count) ? ST_LOAD : ST_EM_RD;
        end
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      err      <= 1'b0;
      sl_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (pt_acc && room) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_CH_SETUP: begin
          if (dw_bad) begin
            err <= 1'b1;
          end
        end
        ST_EM_LAT: begin
          sl_valid <= 1'b1;
        end
        ST_EM_WAIT: begin
          if (!sl_stall) begin
            sl_valid <= 1'b0;
            if (m == count) begin
              count <= '0;
              err   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer indexes and datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        i <= CNT_W'(1);
      end
      ST_I_LAT: begin
        wi   <= rd_w;
        si   <= rd_s;
        a    <= i - CNT_W'(1);
        pool <= 1'b0;
      end
      ST_CH_SUB: begin
        if (a == '0) begin
          dsum <= (S_W+1)'(si);
          dw   <= (W_W+1)'(wi);
        end else begin
          dsum <= (S_W+1)'(si) - (S_W+1)'(rd_s);
          dw   <= {1'b0, wi} - {1'b0, rd_w};
        end
      end
      ST_CH_SETUP: begin
        m <= j;
        if (dw_bad) begin
          cur <= bad_slope;
        end
      end
      ST_CH_DIV: begin
        if (div_done) begin
          cur <= sat_slope;
        end
      end
      ST_PUT: begin
        j <= i;
      end
      ST_WH_TEST: begin
        if (j <= CNT_W'(1)) begin
          i <= i + CNT_W'(1);
          m <= CNT_W'(1);
        end
      end
      ST_WH_CMP: begin
        if (left_higher) begin
          j    <= j - CNT_W'(1);
          a    <= j - CNT_W'(2);
          pool <= 1'b1;
        end else begin
          i <= i + CNT_W'(1);
          m <= CNT_W'(1);
        end
      end
      ST_FILL: begin
        if (m != i) begin
          m <= m + CNT_W'(1);
        end
      end
      ST_EM_LAT: begin
        sl_data.slope       <= clip;
        sl_data.zero_weight <= err;
        sl_data.last_slope  <= (m == count);
      end
      ST_EM_WAIT: begin
        if (!sl_stall) begin
          m <= m + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/gcms_chk.sv =====
// ----------------------------------------------------------------------------
// gcms_chk
// Port-level checks for the convex minorant slope block, bound to the top.
// ----------------------------------------------------------------------------
module gcms_chk import gcms_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   pt_valid,
  input logic   pt_stall,
  input point_t pt_data,
  input logic   sl_valid,
  input logic   sl_stall,
  input slope_t sl_data
);

  // No point is taken while slopes are being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && !pt_stall) |-> !sl_valid)
    else $error("point accepted while a slope is pending");

  // Emitted slopes stay within [0,1]
  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    sl_valid |-> (sl_data.slope <= SLOPE_ONE))
    else $error("slope out of range");

  // A point without the last mark leaves the block ready for the next one
  a_ready_after_point: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && !pt_stall && !pt_data.last_point) |=> !pt_stall)
    else $error("block busy after a non-final point");

  // Taking the final slope ends the diagram
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (sl_valid && !sl_stall && sl_data.last_slope) |=> (!sl_valid && !pt_stall))
    else $error("output continues after the final slope");

  // Stalled slope transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (sl_valid && sl_stall) |=> (sl_valid && $stable(sl_data)))
    else $error("stalled slope changed");

endmodule

bind greatest_convex_minorant_slopes gcms_chk u_chk (.*);

// ===== tb/sv/gcms_slope_checker.sv =====
// ----------------------------------------------------------------------------
// gcms_slope_checker
// Watches the point and slope channels of the convex minorant block, keeps
// its own copy of the stored diagram, works out the clipped minorant slopes
// when the last point of a diagram is taken, and compares each emitted slope
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module gcms_slope_checker import gcms_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pt_valid,
  input  logic   pt_stall,
  input  point_t pt_data,
  input  logic   sl_valid,
  input  logic   sl_stall,
  input  slope_t sl_data,
  output int     mismatches,
  output int     outstanding
);

  // Shadow of the diagram held by the block
  logic [W_W-1:0]         weight_mem [MAX_POINTS];
  logic signed [S_W-1:0]  sum_mem    [MAX_POINTS];
  logic signed [SL_W-1:0] minorant   [MAX_POINTS+1];  // entry 0 is the origin
  int                     stored;
  logic                   flat_seen;

  // Slopes owed by the block, oldest first
  slope_t owed_slopes[$];
  int     miss_count = 0;
  int     owed_now   = 0;

  assign mismatches  = miss_count;
  assign outstanding = owed_now;

  task automatic flag_mismatch(string what);
    miss_count++;
    $display("[%0t] slope mismatch: %s", $time, what);
  endtask

  function automatic logic [W_W-1:0] point_weight(int k);
    return (k == 0) ? '0 : weight_mem[k-1];
  endfunction

  function automatic logic signed [S_W-1:0] point_sum(int k);
    return (k == 0) ? '0 : sum_mem[k-1];
  endfunction

  // Chord slope from point a to point b in signed Q32.16, saturated to 48 bits
  function automatic logic signed [SL_W-1:0] chord_slope(int a, int b);
    logic signed [S_W:0] dsum;
    logic signed [W_W:0] dw;
    logic [S_W:0]        mag49;
    logic [63:0]         mag;
    logic [63:0]         q;
    dsum = point_sum(b) - point_sum(a);
    dw   = $signed({1'b0, point_weight(b)}) - $signed({1'b0, point_weight(a)});
    // Weight not increasing: saturate by the sign of the sum difference
    if (dw <= 0) begin
      flat_seen = 1'b1;
      return (dsum >= 0) ? SLOPE_MAX : SLOPE_MIN;
    end
    mag49 = (dsum < 0) ? -dsum : dsum;
    mag   = {15'b0, mag49} << FRAC_BITS;
    q     = mag / {24'b0, dw[W_W-1:0]};
    if (q > {16'b0, SLOPE_MAX}) begin
      return (dsum >= 0) ? SLOPE_MAX : SLOPE_MIN;
    end
    return (dsum >= 0) ? $signed(q[SL_W-1:0]) : -$signed(q[SL_W-1:0]);
  endfunction

  // Pool adjacent violators over the stored points, then clip and queue
  function automatic void predict_diagram();
    int                     i;
    int                     j;
    int                     m;
    logic signed [SL_W-1:0] cur;
    slope_t                 r;
    minorant[0] = '0;
    for (i = 1; i <= stored; i++) begin
      cur = chord_slope(i - 1, i);
      minorant[i] = cur;
      j = i;
      // never pools into the origin
      while (j > 1 && minorant[j-1] > minorant[i]) begin
        j--;
        cur = chord_slope(j - 1, i);
        minorant[i] = cur;
        for (m = j; m < i; m++) minorant[m] = cur;
      end
    end
    for (i = 1; i <= stored; i++) begin
      if (minorant[i] <= 0) begin
        r.slope = '0;
      end else if (minorant[i] >= 65536) begin
        r.slope = SLOPE_ONE;
      end else begin
        r.slope = minorant[i][OUT_W-1:0];
      end
      r.zero_weight = flat_seen;
      r.last_slope  = (i == stored);
      owed_slopes.push_back(r);
    end
    stored    = 0;
    flat_seen = 1'b0;
  endfunction

  // Sample both channels once per clock
  always @(posedge clk) begin
    slope_t want;
    if (rst) begin
      stored    = 0;
      flat_seen = 1'b0;
      owed_slopes.delete();
    end else begin
      // Slope transaction: compare with the oldest owed slope
      if (sl_valid && !sl_stall) begin
        if (owed_slopes.size() == 0) begin
          flag_mismatch($sformatf("unexpected slope %0d", sl_data.slope));
        end else begin
          want = owed_slopes.pop_front();
          if (sl_data.slope !== want.slope)
            flag_mismatch($sformatf("slope got %0d want %0d", sl_data.slope, want.slope));
          if (sl_data.zero_weight !== want.zero_weight)
            flag_mismatch($sformatf("zero_weight got %b want %b",
                                    sl_data.zero_weight, want.zero_weight));
          if (sl_data.last_slope !== want.last_slope)
            flag_mismatch($sformatf("last_slope got %b want %b",
                                    sl_data.last_slope, want.last_slope));
        end
      end
      // Point transaction: store unless full, solve on the last point
      if (pt_valid && !pt_stall) begin
        if (stored < MAX_POINTS) begin
          weight_mem[stored] = pt_data.cum_weight;
          sum_mem[stored]    = pt_data.cum_sum;
          stored++;
        end
        if (pt_data.last_point) predict_diagram();
      end
    end
    owed_now <= owed_slopes.size();
  end

endmodule

// ===== tb/sv/tb_greatest_convex_minorant_slopes.sv =====
// ----------------------------------------------------------------------------
// tb_greatest_convex_minorant_slopes
// Drives diagrams into the convex minorant slope block: a directed set of
// corner diagrams, then random ones (mostly monotone weights with random
// slopes, some with a flat or falling weight, some raw noise, two full size
// and one over capacity), with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_greatest_convex_minorant_slopes;
  import gcms_pkg::*;

  logic   clk;
  logic   rst;
  logic   pt_valid;
  logic   pt_stall;
  point_t pt_data;
  logic   sl_valid;
  logic   sl_stall;
  slope_t sl_data;
  int     mismatches;
  int     outstanding;

  point_t point_plan[$];

  greatest_convex_minorant_slopes dut (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .pt_data  (pt_data),
    .sl_valid (sl_valid),
    .sl_stall (sl_stall),
    .sl_data  (sl_data)
  );

  gcms_slope_checker slope_check (
    .clk         (clk),
    .rst         (rst),
    .pt_valid    (pt_valid),
    .pt_stall    (pt_stall),
    .pt_data     (pt_data),
    .sl_valid    (sl_valid),
    .sl_stall    (sl_stall),
    .sl_data     (sl_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 8 unit clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void add_point(logic [W_W-1:0] w, logic [S_W-1:0] s, logic l);
    point_t p;
    p.cum_weight = w;
    p.cum_sum    = s;
    p.last_point = l;
    point_plan.push_back(p);
  endfunction

  // Increasing weights with slopes in about [-0.5, 1.5]; a broken diagram
  // gets one flat or falling weight
  function automatic void add_wellformed(int n, bit broken);
    longint w;
    longint s;
    longint dw;
    longint ds;
    longint r;
    int     shift;
    int     bad;
    int     k;
    w     = 0;
    s     = 0;
    shift = $urandom_range(4, 30);
    bad   = broken ? $urandom_range(0, n - 1) : -1;
    for (k = 0; k < n; k++) begin
      if (k == bad) begin
        dw = $urandom_range(0, 1) ? 0 : -(w / 2);
        ds = longint'($urandom_range(0, 2000)) - 1000;
      end else begin
        dw = $urandom_range(1, 1 << shift);
        r  = longint'($urandom_range(0, 131072)) - 32768;
        ds = (dw * r) >>> 16;
      end
      w += dw;
      s += ds;
      add_point(w[W_W-1:0], s[S_W-1:0], k == n - 1);
    end
  endfunction

  // Raw random fields
  function automatic void add_noise(int n);
    int k;
    for (k = 0; k < n; k++) begin
      add_point(W_W'({$urandom, $urandom}), S_W'({$urandom, $urandom}), k == n - 1);
    end
  endfunction

  // Wait before the next transaction, with runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
    return $urandom_range(0, 19);
  endfunction

  // Stimulus, reset and verdict
  initial begin
    int  gap;
    int  calm;
    int  pick;
    bit  full_a;
    bit  full_b;
    bit  over;
    rst      = 1'b1;
    pt_valid = 1'b0;
    pt_data  = '0;
    calm     = 0;
    full_a   = 1'b0;
    full_b   = 1'b0;
    over     = 1'b0;

    // Directed diagrams
    add_point(65536, 32768, 1);                            // plain half slope
    add_point(0, 0, 1);                                    // zero weight, zero sum
    add_point(0, 48'hFFFF_FFFF_FFFF, 1);                   // zero weight, negative sum
    add_point(40'hFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1);    // both fields at max
    add_point(1, 48'h8000_0000_0000, 1);                   // most negative sum
    add_point(1, 48'h7FFF_FFFF_FFFF, 0);                   // saturated, then pooled
    add_point(2, 48'h8000_0000_0000, 1);
    add_point(100000, 50000, 0);                           // falling weight mid diagram
    add_point(50000, 60000, 0);
    add_point(200000, 100000, 1);
    add_point(65536, 58982, 0);                            // pooling over two points
    add_point(131072, 72089, 0);
    add_point(196608, 104857, 0);
    add_point(262144, 183500, 1);
    add_point(65536, 48'h8000_0000_0000, 1);               // quotient exactly 2^47
    add_point(65536, -48'sd65536, 0);                      // clip to zero and to one
    add_point(131072, 0, 1);
    add_point(65536, 0, 0);                                // repeated weight
    add_point(65536, 0, 1);

    // Random diagrams: mostly small, two full size and one over capacity
    while (point_plan.size() < 360) begin
      if (!full_a && point_plan.size() >= 80) begin
        add_wellformed(64, 1'b0);
        full_a = 1'b1;
      end else if (!over && point_plan.size() >= 170) begin
        add_wellformed($urandom_range(65, 70), 1'b0);
        over = 1'b1;
      end else if (!full_b && point_plan.size() >= 270) begin
        add_wellformed(64, 1'($urandom_range(0, 1)));
        full_b = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 2) add_noise($urandom_range(1, 6));
        else if (pick < 4) add_wellformed($urandom_range(2, 8), 1'b1);
        else if (pick < 6) add_wellformed($urandom_range(9, 20), 1'b0);
        else add_wellformed($urandom_range(1, 8), 1'b0);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Offer each point, holding it until the transaction is taken
    foreach (point_plan[k]) begin
      gap = draw_wait(calm);
      if (gap > 0) begin
        pt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pt_valid <= 1'b1;
      pt_data  <= point_plan[k];
      do @(posedge clk); while (!(pt_valid && !pt_stall));
    end
    pt_valid <= 1'b0;

    // Drain, then allow a few chord times for anything stray
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Slope receiver: random stalls, one long hold-off mid diagram
  initial begin
    int hold;
    int calm;
    int taken;
    calm     = 0;
    taken    = 0;
    sl_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = (taken == 12) ? 400 : draw_wait(calm);
      if (hold > 0) begin
        sl_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      sl_stall <= 1'b0;
      do @(posedge clk); while (!(sl_valid && !sl_stall));
      taken++;
    end
  end

  // Run limit
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
